// ===== hdl/zcdp_pkg.sv =====
package zcdp_pkg;

  localparam logic [31:0] CD_SIG    = 32'h02014B50;
  localparam logic [31:0] SENTINEL  = 32'hFFFFFFFF;
  localparam logic [17:0] HDR_LEN   = 18'd46;
  localparam logic [17:0] HDR_LAST  = 18'd45;
  localparam logic [17:0] LEN_READY = 18'd34;
  localparam logic [7:0]  ASCII_TOP = 8'h80;
  localparam int          FLAG_ENC_BIT  = 0;
  localparam int          FLAG_UTF8_BIT = 11;
  localparam logic [15:0] CP_TWO_LIMIT  = 16'h0800;
  localparam logic [7:0]  LEAD_TWO   = 8'hC0;
  localparam logic [7:0]  LEAD_THREE = 8'hE0;
  localparam logic [7:0]  CONT_MARK  = 8'h80;

  localparam logic [1:0] KIND_NAME   = 2'd0;
  localparam logic [1:0] KIND_RECORD = 2'd1;
  localparam logic [1:0] KIND_STOP   = 2'd2;

  localparam logic [15:0] CP437_HI [128] = '{
    16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h00E5, 16'h00E7,
    16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC, 16'h00C4, 16'h00C5,
    16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6, 16'h00F2, 16'h00FB, 16'h00F9,
    16'h00FF, 16'h00D6, 16'h00DC, 16'h00A2, 16'h00A3, 16'h00A5, 16'h20A7, 16'h0192,
    16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA,
    16'h00BF, 16'h2310, 16'h00AC, 16'h00BD, 16'h00BC, 16'h00A1, 16'h00AB, 16'h00BB,
    16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h2561, 16'h2562, 16'h2556,
    16'h2555, 16'h2563, 16'h2551, 16'h2557, 16'h255D, 16'h255C, 16'h255B, 16'h2510,
    16'h2514, 16'h2534, 16'h252C, 16'h251C, 16'h2500, 16'h253C, 16'h255E, 16'h255F,
    16'h255A, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256C, 16'h2567,
    16'h2568, 16'h2564, 16'h2565, 16'h2559, 16'h2558, 16'h2552, 16'h2553, 16'h256B,
    16'h256A, 16'h2518, 16'h250C, 16'h2588, 16'h2584, 16'h258C, 16'h2590, 16'h2580,
    16'h03B1, 16'h00DF, 16'h0393, 16'h03C0, 16'h03A3, 16'h03C3, 16'h00B5, 16'h03C4,
    16'h03A6, 16'h0398, 16'h03A9, 16'h03B4, 16'h221E, 16'h03C6, 16'h03B5, 16'h2229,
    16'h2261, 16'h00B1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'h00F7, 16'h2248,
    16'h00B0, 16'h2219, 16'h00B7, 16'h221A, 16'h207F, 16'h00B2, 16'h25A0, 16'h00A0
  };

  typedef enum logic [1:0] {NM_NONE, NM_PASS, NM_MAP} name_mode_t;
  typedef enum logic [1:0] {TL_NONE, TL_RECORD, TL_STOP} tail_t;

  typedef struct packed {
    logic [7:0] cd_byte;
    logic       end_of_directory;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  name_byte;
    logic [15:0] entry_index;
    logic [15:0] method;
    logic [31:0] crc_value;
    logic [31:0] compressed_size;
    logic [31:0] plain_size;
    logic [31:0] local_offset;
    logic        unusable;
    logic        name_void;
    logic        run_last;
  } out_word_t;

  typedef struct packed {
    name_mode_t  mode;
    logic [7:0]  raw;
    tail_t       tail;
    logic [15:0] index;
    logic [15:0] method;
    logic [31:0] crc;
    logic [31:0] csize;
    logic [31:0] psize;
    logic [31:0] offset;
    logic        unusable;
    logic        name_void;
  } cmd_t;

endpackage

// ===== hdl/zip_central_directory_parser.sv =====
// A word passes the queue, the back's command register and the output register, which
// sends one word per cycle unless stalled; the front takes one byte per cycle unless the
// queue is full. A CP437 name byte makes two or three words, and a record end one more.
// Reset: synchronous, active low, clears the parser state, the queue and the output
// register; the entry count register resets to zero.
module zip_central_directory_parser #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  zcdp_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output zcdp_pkg::out_word_t out_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);

  zcdp_pkg::cmd_t push_cmd, head_cmd;
  logic           q_push, q_pop, q_empty, q_full;

  zcdp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  zcdp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (push_cmd),
    .pop     (q_pop),
    .rd_data (head_cmd),
    .empty   (q_empty),
    .full    (q_full)
  );

  zcdp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (!q_empty),
    .q_data    (head_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

`ifndef SYNTH
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full))
    else $error("word pushed into a full queue");

  a_tail_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.result_kind != zcdp_pkg::KIND_NAME) |-> out_word.run_last)
    else $error("record or stop word not last of its byte");

  a_name_word_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.result_kind == zcdp_pkg::KIND_NAME)
    |-> !out_word.unusable && !out_word.name_void && (out_word.local_offset == '0))
    else $error("name word carries record fields");
`endif

endmodule

// ===== hdl/zcdp_front.sv =====
module zcdp_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  zcdp_pkg::in_word_t in_word,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data,
  input  logic               q_full,
  output logic               q_push,
  output zcdp_pkg::cmd_t     q_cmd
);

  logic [15:0] entry_count_r;
  logic [17:0] pos_r, pos_nxt;
  logic [15:0] entries_done_r, entries_done_nxt;
  logic        stopped_r, stopped_nxt;
  logic        nul_seen_r, nul_seen_nxt;
  logic [15:0] flags_r, flags_nxt;
  logic [15:0] method_r, method_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] csize_r, csize_nxt;
  logic [31:0] psize_r, psize_nxt;
  logic [15:0] nlen_r, nlen_nxt;
  logic [15:0] elen_r, elen_nxt;
  logic [15:0] clen_r, clen_nxt;
  logic [31:0] off_r, off_nxt;
  logic [17:0] name_end_r, name_end_nxt;
  logic [17:0] last_r, last_nxt;

  logic                 accept, active, sig_bad, in_name, rec_end, nul_now;
  logic [31:0]          sig_sh;
  logic [7:0]           b;
  zcdp_pkg::name_mode_t mode;
  zcdp_pkg::tail_t      tail;

  assign in_stall  = q_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign active    = !stopped_r && (entries_done_r < entry_count_r);
  assign b         = in_word.cd_byte;
  assign sig_sh    = zcdp_pkg::CD_SIG >> {pos_r[1:0], 3'b000};

  always_comb begin
    pos_nxt          = pos_r;
    entries_done_nxt = entries_done_r;
    stopped_nxt      = stopped_r;
    nul_seen_nxt     = nul_seen_r;
    flags_nxt        = flags_r;
    method_nxt       = method_r;
    crc_nxt          = crc_r;
    csize_nxt        = csize_r;
    psize_nxt        = psize_r;
    nlen_nxt         = nlen_r;
    elen_nxt         = elen_r;
    clen_nxt         = clen_r;
    off_nxt          = off_r;
    name_end_nxt     = name_end_r;
    last_nxt         = last_r;
    mode             = zcdp_pkg::NM_NONE;
    tail             = zcdp_pkg::TL_NONE;
    sig_bad          = (pos_r < 18'd4) && (b != sig_sh[7:0]);
    in_name          = (pos_r >= zcdp_pkg::HDR_LEN) && (pos_r < name_end_r) && !nul_seen_r;
    rec_end          = (pos_r >= zcdp_pkg::HDR_LAST) && (pos_r >= last_r);
    nul_now          = nul_seen_r;

    if (accept && active) begin
      if (sig_bad) begin
        tail        = zcdp_pkg::TL_STOP;
        stopped_nxt = 1'b1;
      end else begin
        if (pos_r < zcdp_pkg::HDR_LEN) begin
          case (pos_r[5:0])
            6'd8:  flags_nxt[7:0]    = b;
            6'd9:  flags_nxt[15:8]   = b;
            6'd10: method_nxt[7:0]   = b;
            6'd11: method_nxt[15:8]  = b;
            6'd16: crc_nxt[7:0]      = b;
            6'd17: crc_nxt[15:8]     = b;
            6'd18: crc_nxt[23:16]    = b;
            6'd19: crc_nxt[31:24]    = b;
            6'd20: csize_nxt[7:0]    = b;
            6'd21: csize_nxt[15:8]   = b;
            6'd22: csize_nxt[23:16]  = b;
            6'd23: csize_nxt[31:24]  = b;
            6'd24: psize_nxt[7:0]    = b;
            6'd25: psize_nxt[15:8]   = b;
            6'd26: psize_nxt[23:16]  = b;
            6'd27: psize_nxt[31:24]  = b;
            6'd28: nlen_nxt[7:0]     = b;
            6'd29: nlen_nxt[15:8]    = b;
            6'd30: elen_nxt[7:0]     = b;
            6'd31: elen_nxt[15:8]    = b;
            6'd32: clen_nxt[7:0]     = b;
            6'd33: clen_nxt[15:8]    = b;
            6'd42: off_nxt[7:0]      = b;
            6'd43: off_nxt[15:8]     = b;
            6'd44: off_nxt[23:16]    = b;
            6'd45: off_nxt[31:24]    = b;
            default: ;
          endcase
        end
        // all three lengths are in by this point
        if (pos_r == zcdp_pkg::LEN_READY) begin
          name_end_nxt = zcdp_pkg::HDR_LEN + {2'b00, nlen_r};
          last_nxt     = zcdp_pkg::HDR_LAST + {2'b00, nlen_r} + {2'b00, elen_r}
                         + {2'b00, clen_r};
        end
        if (in_name) begin
          if (b == 8'h00) begin
            nul_now      = 1'b1;
            nul_seen_nxt = 1'b1;
          end else if (flags_r[zcdp_pkg::FLAG_UTF8_BIT] || b < zcdp_pkg::ASCII_TOP) begin
            mode = zcdp_pkg::NM_PASS;
          end else begin
            mode = zcdp_pkg::NM_MAP;
          end
        end
        if (rec_end) begin
          tail             = zcdp_pkg::TL_RECORD;
          entries_done_nxt = entries_done_r + 16'd1;
          pos_nxt          = '0;
          nul_seen_nxt     = 1'b0;
          if (in_word.end_of_directory) begin
            stopped_nxt = 1'b1;
          end
        end else begin
          pos_nxt = pos_r + 18'd1;
          if (in_word.end_of_directory) begin
            tail        = zcdp_pkg::TL_STOP;
            stopped_nxt = 1'b1;
          end
        end
      end
    end

    q_push             = (mode != zcdp_pkg::NM_NONE) || (tail != zcdp_pkg::TL_NONE);
    q_cmd.mode         = mode;
    q_cmd.raw          = b;
    q_cmd.tail         = tail;
    q_cmd.index        = entries_done_r;
    q_cmd.method       = method_nxt;
    q_cmd.crc          = crc_nxt;
    q_cmd.csize        = csize_nxt;
    q_cmd.psize        = psize_nxt;
    q_cmd.offset       = off_nxt;
    q_cmd.unusable     = flags_nxt[zcdp_pkg::FLAG_ENC_BIT] || (csize_nxt == zcdp_pkg::SENTINEL)
                         || (psize_nxt == zcdp_pkg::SENTINEL)
                         || (off_nxt == zcdp_pkg::SENTINEL) || nul_now;
    q_cmd.name_void    = nul_now;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r  <= '0;
      pos_r          <= '0;
      entries_done_r <= '0;
      stopped_r      <= 1'b0;
      nul_seen_r     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        entry_count_r <= cfg_data;
      end
      pos_r          <= pos_nxt;
      entries_done_r <= entries_done_nxt;
      stopped_r      <= stopped_nxt;
      nul_seen_r     <= nul_seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    flags_r    <= flags_nxt;
    method_r   <= method_nxt;
    crc_r      <= crc_nxt;
    csize_r    <= csize_nxt;
    psize_r    <= psize_nxt;
    nlen_r     <= nlen_nxt;
    elen_r     <= elen_nxt;
    clen_r     <= clen_nxt;
    off_r      <= off_nxt;
    name_end_r <= name_end_nxt;
    last_r     <= last_nxt;
  end

endmodule

// ===== hdl/zcdp_queue.sv =====
module zcdp_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  zcdp_pkg::cmd_t wr_data,
  input  logic           pop,
  output zcdp_pkg::cmd_t rd_data,
  output logic           empty,
  output logic           full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  zcdp_pkg::cmd_t mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           do_push, do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == CW'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== hdl/zcdp_back.sv =====
module zcdp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  zcdp_pkg::cmd_t      q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output zcdp_pkg::out_word_t out_word
);

  zcdp_pkg::cmd_t      cur_r, cur_nxt;
  logic                cur_valid_r, cur_valid_nxt;
  logic [1:0]          step_r, step_nxt;
  zcdp_pkg::out_word_t out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [15:0] cp;
  logic        three;
  logic [1:0]  name_n;
  logic [2:0]  total_n;
  logic        last_step, out_free, emit;
  logic [7:0]  nb;
  zcdp_pkg::out_word_t word;

  assign out_valid = out_valid_r;
  assign out_word  = out_r;
  assign cp        = zcdp_pkg::CP437_HI[cur_r.raw[6:0]];
  assign three     = (cp >= zcdp_pkg::CP_TWO_LIMIT);
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    case (cur_r.mode)
      zcdp_pkg::NM_PASS: name_n = 2'd1;
      zcdp_pkg::NM_MAP:  name_n = three ? 2'd3 : 2'd2;
      default:           name_n = 2'd0;
    endcase
    total_n   = {1'b0, name_n} + {2'b00, (cur_r.tail != zcdp_pkg::TL_NONE)};
    last_step = ({1'b0, step_r} == total_n - 3'd1);

    nb = cur_r.raw;
    if (cur_r.mode == zcdp_pkg::NM_MAP) begin
      if (three) begin
        case (step_r)
          2'd0:    nb = zcdp_pkg::LEAD_THREE | {4'h0, cp[15:12]};
          2'd1:    nb = zcdp_pkg::CONT_MARK | {2'b00, cp[11:6]};
          default: nb = zcdp_pkg::CONT_MARK | {2'b00, cp[5:0]};
        endcase
      end else begin
        case (step_r)
          2'd0:    nb = zcdp_pkg::LEAD_TWO | {3'b000, cp[10:6]};
          default: nb = zcdp_pkg::CONT_MARK | {2'b00, cp[5:0]};
        endcase
      end
    end

    word             = '0;
    word.entry_index = cur_r.index;
    word.run_last    = last_step;
    if (step_r < name_n) begin
      word.result_kind = zcdp_pkg::KIND_NAME;
      word.name_byte   = nb;
    end else if (cur_r.tail == zcdp_pkg::TL_RECORD) begin
      word.result_kind     = zcdp_pkg::KIND_RECORD;
      word.method          = cur_r.method;
      word.crc_value       = cur_r.crc;
      word.compressed_size = cur_r.csize;
      word.plain_size      = cur_r.psize;
      word.local_offset    = cur_r.offset;
      word.unusable        = cur_r.unusable;
      word.name_void       = cur_r.name_void;
    end else begin
      word.result_kind = zcdp_pkg::KIND_STOP;
    end

    emit          = cur_valid_r && out_free;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    step_nxt      = step_r;
    if (emit) begin
      out_nxt       = word;
      out_valid_nxt = 1'b1;
      if (last_step) begin
        cur_valid_nxt = 1'b0;
        step_nxt      = 2'd0;
      end else begin
        step_nxt = step_r + 2'd1;
      end
    end
    q_pop = q_valid && (!cur_valid_r || (emit && last_step));
    if (q_pop) begin
      cur_nxt       = q_data;
      cur_valid_nxt = 1'b1;
      step_nxt      = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      step_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    out_r <= out_nxt;
  end

endmodule
